FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the status frame deframer
// Frame layout constants, result codes, the result record and the key chain.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned FRAME_BYTES = 12;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned NUM_FIELDS  = 9;

	localparam logic [POS_W-1:0] LAST_POS  = 4'd11;
	localparam logic [7:0]       HEADER_ID = 8'h2B;

	// key chain constants
	localparam logic [7:0] KEY_ADD0 = 8'h2C;
	localparam logic [7:0] KEY_XOR0 = 8'h6F;
	localparam logic [7:0] KEY_ADD1 = 8'hDF;
	localparam logic [7:0] KEY_XOR1 = 8'h7A;
	localparam logic [7:0] KEY_XOR2 = 8'h2B;
	localparam logic [7:0] KEY_ADD2 = 8'h0D;
	localparam logic [7:0] KEY_XOR3 = 8'hC2;

	typedef enum logic [1:0] {
		RES_OK           = 2'd0,
		RES_BAD_DEVICE   = 2'd1,
		RES_BAD_CHECKSUM = 2'd2
	} result_code_t;

	typedef struct packed {
		result_code_t code;
		logic [3:0]   state_nibble;
		logic [7:0]   status_two;
		logic [7:0]   status_three;
		logic [7:0]   status_four;
		logic [7:0]   current_raw;
		logic [7:0]   status_six;
		logic [7:0]   status_seven;
		logic [7:0]   status_eight;
		logic [7:0]   status_nine;
	} result_t;

	// 7-bit key from the 12-bit sequence number
	function automatic logic [6:0] derive_key(input logic [7:0] lo, input logic [3:0] hi_nib);
		logic [7:0] k;
		k = lo + KEY_ADD0;
		k = k ^ KEY_XOR0;
		k = k + KEY_ADD1;
		k = k ^ KEY_XOR1;
		k = k + {4'd0, hi_nib};
		k = k ^ KEY_XOR2;
		k = k + KEY_ADD2;
		k = k ^ KEY_XOR3;
		return k[6:0];
	endfunction

endpackage

FILE: rtl/sfd_frame_decoder.sv
// ----------------------------------------------------------------------------
// sfd_frame_decoder: per-byte frame state and field decode
// Tracks position, checksum, key and decoded fields; flags the closing byte
// and presents the result for it combinationally.
// ----------------------------------------------------------------------------
module sfd_frame_decoder
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat_en,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       last_beat,
	output result_t    result
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	logic [7:0]       seq_low_q;
	logic [6:0]       key_q;
	logic             header_good_q;
	logic [7:0]       field_q [NUM_FIELDS];

	logic [POS_W-1:0] pos;
	logic [7:0]       sub_byte;
	logic             ok;
	result_code_t     code;

	// start flag restarts the count; out-of-range position folds to byte 0
	always_comb begin
		pos = frame_start ? '0 : pos_q;
		if (pos > LAST_POS) begin
			pos = '0;
		end
	end

	assign last_beat = (pos == LAST_POS);
	assign sub_byte  = rx_byte - {1'b0, key_q};

	always_comb begin
		priority if (!header_good_q) begin
			code = RES_BAD_DEVICE;
		end else if (xor_q != rx_byte) begin
			code = RES_BAD_CHECKSUM;
		end else begin
			code = RES_OK;
		end
	end

	assign ok = (code == RES_OK);

	always_comb begin
		result.code         = code;
		result.state_nibble = ok ? field_q[0][3:0] : 4'd0;
		result.status_two   = ok ? field_q[1] : 8'd0;
		result.status_three = ok ? field_q[2] : 8'd0;
		result.status_four  = ok ? field_q[3] : 8'd0;
		result.current_raw  = ok ? field_q[4] : 8'd0;
		result.status_six   = ok ? field_q[5] : 8'd0;
		result.status_seven = ok ? field_q[6] : 8'd0;
		result.status_eight = ok ? field_q[7] : 8'd0;
		result.status_nine  = ok ? field_q[8] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			xor_q         <= '0;
			seq_low_q     <= '0;
			key_q         <= '0;
			header_good_q <= 1'b0;
		end else if (beat_en) begin
			pos_q <= last_beat ? '0 : pos + 1'b1;
			if (pos == '0) begin
				xor_q         <= rx_byte;
				header_good_q <= (rx_byte == HEADER_ID);
			end else if (!last_beat) begin
				xor_q <= xor_q ^ rx_byte;
			end
			if (pos == 4'd1) begin
				seq_low_q <= rx_byte;
			end
			if (pos == 4'd2) begin
				key_q <= derive_key(seq_low_q, rx_byte[7:4]);
			end
		end
	end

	// field store: no reset, every entry is written before the closing byte
	always_ff @(posedge clk) begin
		if (beat_en) begin
			unique case (pos)
				4'd2:    field_q[0] <= {4'd0, rx_byte[3:0]};
				4'd3:    field_q[1] <= sub_byte;
				4'd4:    field_q[2] <= sub_byte;
				4'd5:    field_q[3] <= sub_byte;
				4'd6:    field_q[4] <= rx_byte;
				4'd7:    field_q[5] <= sub_byte;
				4'd8:    field_q[6] <= sub_byte;
				4'd9:    field_q[7] <= sub_byte;
				4'd10:   field_q[8] <= sub_byte;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/status_frame_deframer_core.sv
// Result path: byte 11 of a frame, once it leaves the input register, is
//   loaded into the result register, which drives its result beat on out_valid.
// Throughput: one input beat per cycle; the input stalls only when byte 11
//   sits in the input register while an earlier result is still stalled.
// Reset (arst_n low): position, checksum, key, header flag and both valid
//   flags clear at once; the decoded field store is not reset.
// ----------------------------------------------------------------------------
// status_frame_deframer_core: 12-byte status frame receiver
// Input register -> byte decoder -> result register, one byte per cycle unless the input stalls.
// ----------------------------------------------------------------------------
module status_frame_deframer_core
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input beats
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	// result beats
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_code,
	output logic [3:0] state_nibble,
	output logic [7:0] status_two,
	output logic [7:0] status_three,
	output logic [7:0] status_four,
	output logic [7:0] current_raw,
	output logic [7:0] status_six,
	output logic [7:0] status_seven,
	output logic [7:0] status_eight,
	output logic [7:0] status_nine
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// decoder interface
	logic    last_beat;
	logic    advance;
	result_t dec_result;

	// result register
	logic    out_valid_q;
	result_t result_q;

	// A byte leaves the input register unless it closes a frame and the
	// result register is still holding an untaken beat.
	assign advance  = valid_s1 && !(last_beat && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	sfd_frame_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_en     (advance),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.last_beat   (last_beat),
		.result      (dec_result)
	);

	// result register: reload is allowed in the cycle the old beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_beat) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_beat) begin
			result_q <= dec_result;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_code  = result_q.code;
	assign state_nibble = result_q.state_nibble;
	assign status_two   = result_q.status_two;
	assign status_three = result_q.status_three;
	assign status_four  = result_q.status_four;
	assign current_raw  = result_q.current_raw;
	assign status_six   = result_q.status_six;
	assign status_seven = result_q.status_seven;
	assign status_eight = result_q.status_eight;
	assign status_nine  = result_q.status_nine;

	// failed frames carry all-zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_q.code != RES_OK |->
			result_q.state_nibble == 4'd0 && result_q.status_two == 8'd0 &&
			result_q.current_raw == 8'd0 && result_q.status_nine == 8'd0)
		else $error("failed frame result has nonzero fields");

	// input only stalls behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_beat && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// a new result beat always comes from a closing byte in the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && last_beat))
		else $error("result beat without a closing byte");

endmodule
